FILE: src/lcm_pkg.sv
// Shared types and constants for the letterbox coordinate mapper.
package lcm_pkg;

  // Field widths
  localparam int SZ_W   = 16;             // physical sizes and coordinates
  localparam int LG_W   = 12;             // logical coordinates and reference sizes
  localparam int PROD_W = SZ_W + LG_W;    // size times logical value

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = SZ_W;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;

  // Queue between classifier and execution pipe
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    CMD_POINT = 2'd0,
    CMD_RECT  = 2'd1,
    CMD_SCALE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  // Derived viewport
  typedef struct packed {
    logic            valid;
    logic [SZ_W-1:0] left;
    logic [SZ_W-1:0] top;
    logic [SZ_W-1:0] width;
    logic [SZ_W-1:0] height;
  } view_t;

  // Classified item as queued for execution
  typedef struct packed {
    cmd_t            cmd;
    logic            ok;
    logic [LG_W-1:0] ax;   // x, or clamped length for scale
    logic [LG_W-1:0] ay;
    logic [LG_W-1:0] ex;   // x + w for rectangles
    logic [LG_W-1:0] ey;   // y + h for rectangles
  } item_t;

endpackage

FILE: src/lcm_cdiv.sv
// Registered divide by a constant through a reciprocal multiply.
module lcm_cdiv #(
  parameter int DIVISOR = 1
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [lcm_pkg::PROD_W-1:0] n,
  output logic [lcm_pkg::SZ_W-1:0]   q
);

  // m = ceil(2^s / d) with s = k + ceil(log2 d) is exact for all n < 2^k
  localparam int LOG_D  = $clog2(DIVISOR);
  localparam int SHIFT  = lcm_pkg::PROD_W + LOG_D;
  localparam int MULT_W = lcm_pkg::PROD_W + 2;
  localparam int FULL_W = lcm_pkg::PROD_W + MULT_W;
  localparam longint unsigned MULT = ((64'd1 << SHIFT) + DIVISOR - 1) / DIVISOR;
  localparam logic [MULT_W-1:0] MULT_V = MULT[MULT_W-1:0];

  logic [FULL_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= FULL_W'(n) * FULL_W'(MULT_V);
    end
  end

  // quotient always fits the size field where it is used
  assign q = prod_r[SHIFT +: lcm_pkg::SZ_W];

endmodule

FILE: src/lcm_view.sv
// Screen size registers and the pipelined viewport derivation.
module lcm_view #(
  parameter int REF_WIDTH  = 1024,
  parameter int REF_HEIGHT = 768
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lcm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lcm_pkg::CFG_DATA_W-1:0] cfg_data,
  output lcm_pkg::view_t                 view,
  output logic                           busy
);

  localparam logic [lcm_pkg::LG_W-1:0] RW_L = REF_WIDTH[lcm_pkg::LG_W-1:0];
  localparam logic [lcm_pkg::LG_W-1:0] RH_L = REF_HEIGHT[lcm_pkg::LG_W-1:0];

  logic [lcm_pkg::SZ_W-1:0]   sw_r, sh_r, sw_nxt, sh_nxt;
  logic                       d1_v_r, d1_v_nxt, d2_v_r, d3_v_r;
  logic [lcm_pkg::PROD_W-1:0] a_r, b_r;
  logic                       le_r;
  logic [lcm_pkg::SZ_W-1:0]   qa, qb;
  lcm_pkg::view_t             view_r, view_nxt;
  logic [lcm_pkg::SZ_W-1:0]   vw, vh;

  // register write decode
  always_comb begin
    sw_nxt   = sw_r;
    sh_nxt   = sh_r;
    d1_v_nxt = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        lcm_pkg::REG_SCREEN_WIDTH: begin
          sw_nxt   = cfg_data;
          d1_v_nxt = 1'b1;
        end
        lcm_pkg::REG_SCREEN_HEIGHT: begin
          sh_nxt   = cfg_data;
          d1_v_nxt = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // stage 1: cross products of screen and reference sizes (their comparison is registered in stage 2)
  always_ff @(posedge clk) begin
    a_r <= lcm_pkg::PROD_W'(sw_r) * lcm_pkg::PROD_W'(RH_L);
    b_r <= lcm_pkg::PROD_W'(sh_r) * lcm_pkg::PROD_W'(RW_L);
    le_r <= (a_r <= b_r);
  end

  // stage 2: both candidate quotients
  lcm_cdiv #(.DIVISOR(REF_WIDTH)) u_div_a (
    .clk (clk),
    .en  (1'b1),
    .n   (a_r),
    .q   (qa)
  );

  lcm_cdiv #(.DIVISOR(REF_HEIGHT)) u_div_b (
    .clk (clk),
    .en  (1'b1),
    .n   (b_r),
    .q   (qb)
  );

  // final: pick the fitting side, center, reject degenerate screens
  always_comb begin
    vw = le_r ? sw_r : qb;
    vh = le_r ? qa : sh_r;
    view_nxt = '0;
    if (sw_r != '0 && sh_r != '0 && vw != '0 && vh != '0) begin
      view_nxt.valid  = 1'b1;
      view_nxt.left   = (sw_r - vw) >> 1;
      view_nxt.top    = (sh_r - vh) >> 1;
      view_nxt.width  = vw;
      view_nxt.height = vh;
    end
  end

  // size registers, derivation tracking and the viewport register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r   <= '0;
      sh_r   <= '0;
      d1_v_r <= 1'b0;
      d2_v_r <= 1'b0;
      d3_v_r <= 1'b0;
      view_r <= '0;
    end else begin
      sw_r   <= sw_nxt;
      sh_r   <= sh_nxt;
      d1_v_r <= d1_v_nxt;
      d2_v_r <= d1_v_r;
      d3_v_r <= d2_v_r;
      if (d3_v_r) begin
        view_r <= view_nxt;
      end
    end
  end

  assign view = view_r;
  assign busy = cfg_we | d1_v_r | d2_v_r | d3_v_r;

endmodule

FILE: src/lcm_front.sv
// Input acceptance, command classification and the item queue.
module lcm_front #(
  parameter int REF_WIDTH  = 1024,
  parameter int REF_HEIGHT = 768
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_command,
  input  logic [lcm_pkg::LG_W-1:0]  in_logical_x,
  input  logic [lcm_pkg::LG_W-1:0]  in_logical_y,
  input  logic [lcm_pkg::LG_W-1:0]  in_logical_w,
  input  logic [lcm_pkg::LG_W-1:0]  in_logical_h,
  input  logic                      view_valid,
  input  logic                      busy,
  output logic                      q_valid,
  output lcm_pkg::item_t            q_head,
  input  logic                      q_pop
);

  localparam logic [lcm_pkg::LG_W:0] RW_L = REF_WIDTH[lcm_pkg::LG_W:0];
  localparam logic [lcm_pkg::LG_W:0] RH_L = REF_HEIGHT[lcm_pkg::LG_W:0];

  lcm_pkg::item_t              item;
  logic [lcm_pkg::LG_W:0]      x_e, y_e, w_e, h_e, end_x, end_y;
  logic                        x_in, y_in;

  lcm_pkg::item_t              q_r [lcm_pkg::QDEPTH];
  logic [lcm_pkg::QPTR_W-1:0]  wr_r, rd_r;
  logic [lcm_pkg::QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic                        push, full;

  // classify: range checks and operand selection
  always_comb begin
    x_e   = {1'b0, in_logical_x};
    y_e   = {1'b0, in_logical_y};
    w_e   = {1'b0, in_logical_w};
    h_e   = {1'b0, in_logical_h};
    end_x = x_e + w_e;
    end_y = y_e + h_e;
    x_in  = (x_e <= RW_L);
    y_in  = (y_e <= RH_L);

    item.cmd = lcm_pkg::cmd_t'(in_command);
    item.ax  = in_logical_x;
    item.ay  = in_logical_y;
    item.ex  = end_x[lcm_pkg::LG_W-1:0];
    item.ey  = end_y[lcm_pkg::LG_W-1:0];
    item.ok  = 1'b0;
    unique case (item.cmd)
      lcm_pkg::CMD_POINT: item.ok = view_valid & x_in & y_in;
      lcm_pkg::CMD_RECT: begin
        item.ok = view_valid & (in_logical_w != '0) & (in_logical_h != '0) &
                  x_in & y_in & (end_x <= RW_L) & (end_y <= RH_L);
      end
      lcm_pkg::CMD_SCALE: begin
        item.ok = view_valid & (in_logical_w != '0);
        // clamp length to the reference width
        item.ax = (w_e > RW_L) ? RW_L[lcm_pkg::LG_W-1:0] : in_logical_w;
      end
      lcm_pkg::CMD_READ: item.ok = view_valid;
    endcase
  end

  // item queue
  assign full     = (cnt_r == lcm_pkg::QCNT_W'(lcm_pkg::QDEPTH));
  assign in_ready = ~full & ~busy;
  assign push     = in_valid & in_ready;
  assign q_valid  = (cnt_r != '0);
  assign q_head   = q_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    case ({push, q_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_r] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (q_pop) begin
        rd_r <= rd_r + 1'b1;
      end
    end
  end

endmodule

FILE: src/lcm_back.sv
// Execution pipe: scale products, constant divides, result assembly.
module lcm_back #(
  parameter int REF_WIDTH  = 1024,
  parameter int REF_HEIGHT = 768
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  lcm_pkg::view_t            view,
  input  logic                      q_valid,
  input  lcm_pkg::item_t            q_head,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_ok,
  output logic [lcm_pkg::SZ_W-1:0]  out_phys_x,
  output logic [lcm_pkg::SZ_W-1:0]  out_phys_y,
  output logic [lcm_pkg::SZ_W-1:0]  out_phys_w,
  output logic [lcm_pkg::SZ_W-1:0]  out_phys_h
);

  logic                       adv;
  logic                       s1_v_r, s2_v_r, out_v_r;
  lcm_pkg::cmd_t              s1_cmd_r, s2_cmd_r;
  logic                       s1_ok_r, s2_ok_r;
  logic [lcm_pkg::PROD_W-1:0] p_sx_r, p_sy_r, p_ex_r, p_ey_r;
  logic [lcm_pkg::SZ_W-1:0]   q_sx, q_sy, q_ex, q_ey;

  logic                       ok_nxt, ok_r;
  logic [lcm_pkg::SZ_W-1:0]   x_nxt, y_nxt, w_nxt, h_nxt;
  logic [lcm_pkg::SZ_W-1:0]   x_r, y_r, w_r, h_r;

  // whole pipe moves unless the output beat is blocked
  assign adv   = ~out_v_r | out_ready;
  assign q_pop = adv & q_valid;

  // stage 1: logical value times viewport size
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_cmd_r <= q_head.cmd;
      s1_ok_r  <= q_head.ok;
      p_sx_r   <= lcm_pkg::PROD_W'(q_head.ax) * lcm_pkg::PROD_W'(view.width);
      p_sy_r   <= lcm_pkg::PROD_W'(q_head.ay) * lcm_pkg::PROD_W'(view.height);
      p_ex_r   <= lcm_pkg::PROD_W'(q_head.ex) * lcm_pkg::PROD_W'(view.width);
      p_ey_r   <= lcm_pkg::PROD_W'(q_head.ey) * lcm_pkg::PROD_W'(view.height);
    end
  end

  // stage 2: divide by the reference sizes
  lcm_cdiv #(.DIVISOR(REF_WIDTH)) u_div_sx (
    .clk (clk), .en (adv), .n (p_sx_r), .q (q_sx)
  );
  lcm_cdiv #(.DIVISOR(REF_HEIGHT)) u_div_sy (
    .clk (clk), .en (adv), .n (p_sy_r), .q (q_sy)
  );
  lcm_cdiv #(.DIVISOR(REF_WIDTH)) u_div_ex (
    .clk (clk), .en (adv), .n (p_ex_r), .q (q_ex)
  );
  lcm_cdiv #(.DIVISOR(REF_HEIGHT)) u_div_ey (
    .clk (clk), .en (adv), .n (p_ey_r), .q (q_ey)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_cmd_r <= s1_cmd_r;
      s2_ok_r  <= s1_ok_r;
    end
  end

  // result assembly per command
  always_comb begin
    ok_nxt = s2_ok_r;
    x_nxt  = view.left + q_sx;
    y_nxt  = view.top + q_sy;
    w_nxt  = '0;
    h_nxt  = '0;
    unique case (s2_cmd_r)
      lcm_pkg::CMD_POINT: ;
      lcm_pkg::CMD_RECT: begin
        // a rectangle that collapses after mapping is rejected
        ok_nxt = s2_ok_r & (q_ex > q_sx) & (q_ey > q_sy);
        w_nxt  = q_ex - q_sx;
        h_nxt  = q_ey - q_sy;
      end
      lcm_pkg::CMD_SCALE: begin
        x_nxt = '0;
        y_nxt = '0;
        w_nxt = (q_sx == '0) ? lcm_pkg::SZ_W'(1) : q_sx;
      end
      lcm_pkg::CMD_READ: begin
        x_nxt = view.left;
        y_nxt = view.top;
        w_nxt = view.width;
        h_nxt = view.height;
      end
    endcase
    if (!ok_nxt && s2_cmd_r != lcm_pkg::CMD_READ) begin
      x_nxt = '0;
      y_nxt = '0;
      w_nxt = '0;
      h_nxt = '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (adv) begin
      ok_r <= ok_nxt;
      x_r  <= x_nxt;
      y_r  <= y_nxt;
      w_r  <= w_nxt;
      h_r  <= h_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r  <= q_valid;
      s2_v_r  <= s1_v_r;
      out_v_r <= s2_v_r;
    end
  end

  assign out_valid  = out_v_r;
  assign out_ok     = ok_r;
  assign out_phys_x = x_r;
  assign out_phys_y = y_r;
  assign out_phys_w = w_r;
  assign out_phys_h = h_r;

endmodule

FILE: src/letterbox_coordinate_mapper.sv
// An accepted input beat passes the queue slot, the product and reciprocal-multiply
//   stages and the output register before its result beat appears on the output.
// Throughput: one item per cycle unless out_ready stalls the pipe; the pipelined
//   constant-divide multipliers set this. A register write holds in_ready low
//   for that cycle and while the viewport derivation pipe that follows it runs.
// Reset (synchronous, rst_n low) zeroes screen sizes and marks the viewport invalid.
module letterbox_coordinate_mapper #(
  parameter int REF_WIDTH  = 1024,
  parameter int REF_HEIGHT = 768
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lcm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lcm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_command,
  input  logic [lcm_pkg::LG_W-1:0]       in_logical_x,
  input  logic [lcm_pkg::LG_W-1:0]       in_logical_y,
  input  logic [lcm_pkg::LG_W-1:0]       in_logical_w,
  input  logic [lcm_pkg::LG_W-1:0]       in_logical_h,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_ok,
  output logic [lcm_pkg::SZ_W-1:0]       out_phys_x,
  output logic [lcm_pkg::SZ_W-1:0]       out_phys_y,
  output logic [lcm_pkg::SZ_W-1:0]       out_phys_w,
  output logic [lcm_pkg::SZ_W-1:0]       out_phys_h
);

  lcm_pkg::view_t view;
  lcm_pkg::item_t q_head;
  logic           busy, q_valid, q_pop;

  // viewport registers and derivation
  lcm_view #(
    .REF_WIDTH  (REF_WIDTH),
    .REF_HEIGHT (REF_HEIGHT)
  ) u_view (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .view      (view),
    .busy      (busy)
  );

  // accept and classify
  lcm_front #(
    .REF_WIDTH  (REF_WIDTH),
    .REF_HEIGHT (REF_HEIGHT)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_command   (in_command),
    .in_logical_x (in_logical_x),
    .in_logical_y (in_logical_y),
    .in_logical_w (in_logical_w),
    .in_logical_h (in_logical_h),
    .view_valid   (view.valid),
    .busy         (busy),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .q_pop        (q_pop)
  );

  // execute
  lcm_back #(
    .REF_WIDTH  (REF_WIDTH),
    .REF_HEIGHT (REF_HEIGHT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .view       (view),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_ok     (out_ok),
    .out_phys_x (out_phys_x),
    .out_phys_y (out_phys_y),
    .out_phys_w (out_phys_w),
    .out_phys_h (out_phys_h)
  );

endmodule
